/* hdl/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the two-byte EEPROM access I2C master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // register map (byte addresses)
    localparam int         ADDR_W          = 3;
    localparam logic [2:0] ADDR_HOLD_TICKS = 3'd0;
    localparam logic [2:0] ADDR_DEV_ADDR   = 3'd4;

    // reset values
    localparam logic [7:0] HOLD_TICKS_RST = 8'd6;
    localparam logic [6:0] DEV_ADDR_RST   = 7'd80;

    // bus sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_A   = 4'd1,
        PH_START_B   = 4'd2,
        PH_TX_LOW1   = 4'd3,
        PH_TX_LOW2   = 4'd4,
        PH_TX_HIGH   = 4'd5,
        PH_ACKW_HIGH = 4'd6,
        PH_ACKW_LOW  = 4'd7,
        PH_RX_HIGH   = 4'd8,
        PH_RX_LOW    = 4'd9,
        PH_ACKS_LOW  = 4'd10,
        PH_ACKS_HIGH = 4'd11,
        PH_ACKS_REL  = 4'd12,
        PH_STOP_A    = 4'd13,
        PH_STOP_B    = 4'd14
    } t_phase;

    // configuration register contents
    typedef struct packed {
        logic [7:0] hold_ticks;
        logic [6:0] device_address;
    } t_cfg;

    // per-tick result of the sequencer
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] read_first;
        logic [7:0] read_second;
    } t_step_res;

endpackage

/* hdl/i2c_master_eeprom_two_byte_access.sv */
// Results: a request is taken into the input register, then moves on into the result
//   register; one request per cycle sustained while i_stall does not hold the result.
// Each request is one bus tick; the sequencer state, held in i2cm_seq, moves
//   on when the request leaves the input register for the result register.
// Reset (synchronous, active low): sequencer idle, SCL and SDA released high,
//   received bytes zero, hold ticks 6, device address 80, both stages empty.
// ----------------------------------------------------------------------------
// i2c_master_eeprom_two_byte_access
// I2C master performing two-byte EEPROM writes and reads, one tick per request.
// ----------------------------------------------------------------------------
module i2c_master_eeprom_two_byte_access
    import i2cm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_cmd,
    input  logic [7:0]        i_word_address,
    input  logic [7:0]        i_write_first,
    input  logic [7:0]        i_write_second,
    input  logic              i_sda_in,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_scl_out,
    output logic              o_sda_out,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic [7:0]        o_read_first,
    output logic [7:0]        o_read_second,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg       cfg;
    t_step_res  step_res;

    // input register
    logic       r_in_valid;
    logic [1:0] r_cmd;
    logic [7:0] r_word_address;
    logic [7:0] r_write_first;
    logic [7:0] r_write_second;
    logic       r_sda_in;

    logic       r_out_valid;
    logic       adv;      // result register free to load
    logic       load;     // request taken into input register
    logic       step;     // request moves into result register: one bus tick

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !adv;
    assign load    = i_valid && !o_stall;
    assign step    = r_in_valid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd          <= i_cmd;
            r_word_address <= i_word_address;
            r_write_first  <= i_write_first;
            r_write_second <= i_write_second;
            r_sda_in       <= i_sda_in;
        end
    end

    i2cm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    i2cm_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_cmd          (r_cmd),
        .i_word_address (r_word_address),
        .i_write_first  (r_write_first),
        .i_write_second (r_write_second),
        .i_sda_in       (r_sda_in),
        .i_cfg          (cfg),
        .o_res          (step_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            o_scl_out     <= step_res.scl;
            o_sda_out     <= step_res.sda;
            o_busy_res    <= step_res.busy;
            o_done_res    <= step_res.done;
            o_read_first  <= step_res.read_first;
            o_read_second <= step_res.read_second;
        end
    end

    assign o_valid = r_out_valid;

endmodule

/* hdl/i2cm_regs.sv */
// ----------------------------------------------------------------------------
// i2cm_regs
// APB-style configuration registers: hold ticks and device address.
// ----------------------------------------------------------------------------
module i2cm_regs
    import i2cm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [7:0] r_hold_ticks;
    logic [6:0] r_dev_addr;
    logic       wr_en;
    logic       sel_dev;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    // decode on the word-select bit only
    assign sel_dev = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks <= HOLD_TICKS_RST;
            r_dev_addr   <= DEV_ADDR_RST;
        end else if (wr_en) begin
            if (sel_dev == ADDR_DEV_ADDR[2]) begin
                r_dev_addr <= pwdata[6:0];
            end else if (sel_dev == ADDR_HOLD_TICKS[2]) begin
                r_hold_ticks <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (sel_dev == ADDR_DEV_ADDR[2]) begin
            prdata = {25'd0, r_dev_addr};
        end else begin
            prdata = {24'd0, r_hold_ticks};
        end
    end

    assign o_cfg.hold_ticks     = r_hold_ticks;
    assign o_cfg.device_address = r_dev_addr;

endmodule

/* hdl/i2cm_seq.sv */
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: advances the pin sequence by one tick per step.
// ----------------------------------------------------------------------------
module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_word_address,
    input  logic [7:0] i_write_first,
    input  logic [7:0] i_write_second,
    input  logic       i_sda_in,
    input  t_cfg       i_cfg,
    output t_step_res  o_res
);

    t_phase     r_phase, n_phase, ph_e;
    logic       r_is_read, n_is_read;
    logic [2:0] r_bit_count, n_bit_count, bc_e;
    logic [2:0] r_byte_index, n_byte_index, bi_e, bi_inc;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_hold, n_hold, hold_e, hold_inc, limit;
    logic [7:0] r_latched [3];
    logic [7:0] n_latched [3];
    logic [7:0] r_rx [2];
    logic [7:0] n_rx [2];
    logic       r_scl, n_scl, scl_e;
    logic       r_sda, n_sda, sda_e;
    logic       start, busy, hold_end;

    // byte to send for a given byte index
    function automatic logic [7:0] tx_byte(
        input logic [2:0] bi,
        input logic       rd,
        input logic [6:0] dev,
        input logic [7:0] lb0,
        input logic [7:0] lb1,
        input logic [7:0] lb2
    );
        logic [7:0] b;
        if (bi == 3'd0) begin
            b = {dev, 1'b0};
        end else if (rd && bi == 3'd2) begin
            b = {dev, 1'b1};
        end else begin
            case (bi)
                3'd2, 3'd5: b = lb1;
                3'd3, 3'd6: b = lb2;
                default:    b = lb0;
            endcase
        end
        return b;
    endfunction

    // state seen by this tick, with a fresh command folded in
    assign start    = (r_phase == PH_IDLE) && (i_cmd == CMD_WRITE || i_cmd == CMD_READ);
    assign ph_e     = start ? PH_START_A : r_phase;
    assign scl_e    = start ? 1'b1 : r_scl;
    assign sda_e    = start ? 1'b1 : r_sda;
    assign hold_e   = start ? 8'd0 : r_hold;
    assign bi_e     = start ? 3'd0 : r_byte_index;
    assign bc_e     = start ? 3'd0 : r_bit_count;
    assign bi_inc   = bi_e + 3'd1;
    assign busy     = (ph_e != PH_IDLE);
    assign hold_inc = (hold_e == 8'hFF) ? 8'hFF : hold_e + 8'd1;
    assign limit    = (i_cfg.hold_ticks == 8'd0) ? 8'd1 : i_cfg.hold_ticks;
    assign hold_end = busy && (hold_inc >= limit);

    always_comb begin
        n_is_read    = start ? (i_cmd == CMD_READ) : r_is_read;
        n_latched[0] = start ? i_word_address : r_latched[0];
        n_latched[1] = start ? i_write_first  : r_latched[1];
        n_latched[2] = start ? i_write_second : r_latched[2];
    end

    // next phase
    always_comb begin
        n_phase = ph_e;
        if (hold_end) begin
            case (ph_e)
                PH_START_A:   n_phase = PH_START_B;
                PH_START_B:   n_phase = PH_TX_LOW1;
                PH_TX_LOW1:   n_phase = PH_TX_LOW2;
                PH_TX_LOW2:   n_phase = PH_TX_HIGH;
                PH_TX_HIGH:   n_phase = (bc_e == 3'd7) ? PH_ACKW_HIGH : PH_TX_LOW1;
                PH_ACKW_HIGH: n_phase = PH_ACKW_LOW;
                PH_ACKW_LOW: begin
                    if (!n_is_read) begin
                        n_phase = (bi_inc <= 3'd3) ? PH_TX_LOW1 : PH_STOP_A;
                    end else if (bi_inc == 3'd1) begin
                        n_phase = PH_TX_LOW1;
                    end else if (bi_inc == 3'd2) begin
                        n_phase = PH_START_A;
                    end else begin
                        n_phase = PH_RX_HIGH;
                    end
                end
                PH_RX_HIGH:   n_phase = PH_RX_LOW;
                PH_RX_LOW:    n_phase = (bc_e == 3'd7) ? PH_ACKS_LOW : PH_RX_HIGH;
                PH_ACKS_LOW:  n_phase = PH_ACKS_HIGH;
                PH_ACKS_HIGH: n_phase = PH_ACKS_REL;
                PH_ACKS_REL:  n_phase = (bi_inc == 3'd4) ? PH_RX_HIGH : PH_STOP_A;
                PH_STOP_A:    n_phase = PH_STOP_B;
                default:      n_phase = PH_IDLE;
            endcase
        end
    end

    // datapath and pin levels
    always_comb begin
        n_shift      = r_shift;
        n_bit_count  = bc_e;
        n_byte_index = bi_e;
        n_scl        = scl_e;
        n_sda        = sda_e;
        n_hold       = busy ? hold_inc : hold_e;
        n_rx[0]      = r_rx[0];
        n_rx[1]      = r_rx[1];
        o_res.done   = 1'b0;
        if (hold_end) begin
            n_hold = 8'd0;
            case (ph_e)
                PH_START_A: begin
                    n_scl = 1'b1;
                    n_sda = 1'b0;
                end
                PH_START_B: begin
                    n_shift     = tx_byte(bi_e, n_is_read, i_cfg.device_address,
                                          n_latched[0], n_latched[1], n_latched[2]);
                    n_bit_count = 3'd0;
                    n_scl       = 1'b0;
                end
                PH_TX_LOW1: begin
                    n_scl = 1'b0;
                    n_sda = r_shift[7];
                end
                PH_TX_LOW2: n_scl = 1'b1;
                PH_TX_HIGH: begin
                    n_shift = {r_shift[6:0], 1'b0};
                    if (bc_e == 3'd7) begin
                        n_bit_count = 3'd0;
                        n_scl       = 1'b1;
                    end else begin
                        n_bit_count = bc_e + 3'd1;
                        n_scl       = 1'b0;
                    end
                end
                PH_ACKW_HIGH: n_scl = 1'b0;
                PH_ACKW_LOW: begin
                    n_byte_index = bi_inc;
                    if ((!n_is_read && bi_inc <= 3'd3) || (n_is_read && bi_inc == 3'd1)) begin
                        n_shift     = tx_byte(bi_inc, n_is_read, i_cfg.device_address,
                                              n_latched[0], n_latched[1], n_latched[2]);
                        n_bit_count = 3'd0;
                        n_scl       = 1'b0;
                    end else if (!n_is_read) begin
                        n_scl = 1'b1;
                        n_sda = 1'b0;
                    end else if (bi_inc == 3'd2) begin
                        // repeated start
                        n_scl = 1'b1;
                        n_sda = 1'b1;
                    end else begin
                        n_shift     = 8'd0;
                        n_bit_count = 3'd0;
                        n_scl       = 1'b1;
                    end
                end
                PH_RX_HIGH: begin
                    n_shift = {r_shift[6:0], i_sda_in};
                    n_scl   = 1'b0;
                end
                PH_RX_LOW: begin
                    if (bc_e == 3'd7) begin
                        if (bi_e == 3'd4) begin
                            n_rx[1] = r_shift;
                        end else begin
                            n_rx[0] = r_shift;
                        end
                        n_scl = 1'b0;
                        n_sda = (bi_e == 3'd4);  // nack on the last byte
                    end else begin
                        n_bit_count = bc_e + 3'd1;
                        n_scl       = 1'b1;
                    end
                end
                PH_ACKS_LOW:  n_scl = 1'b1;
                PH_ACKS_HIGH: begin
                    n_scl = 1'b0;
                    n_sda = 1'b1;
                end
                PH_ACKS_REL: begin
                    n_byte_index = bi_inc;
                    if (bi_inc == 3'd4) begin
                        n_shift     = 8'd0;
                        n_bit_count = 3'd0;
                        n_scl       = 1'b1;
                    end else begin
                        n_scl = 1'b1;
                        n_sda = 1'b0;
                    end
                end
                PH_STOP_A: begin
                    n_scl = 1'b1;
                    n_sda = 1'b1;
                end
                default: begin
                    n_scl      = 1'b1;
                    n_sda      = 1'b1;
                    o_res.done = 1'b1;
                end
            endcase
        end
        o_res.scl         = scl_e;
        o_res.sda         = sda_e;
        o_res.busy        = busy;
        o_res.read_first  = n_rx[0];
        o_res.read_second = n_rx[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_is_read    <= 1'b0;
            r_bit_count  <= 3'd0;
            r_byte_index <= 3'd0;
            r_shift      <= 8'd0;
            r_hold       <= 8'd0;
            r_latched[0] <= 8'd0;
            r_latched[1] <= 8'd0;
            r_latched[2] <= 8'd0;
            r_rx[0]      <= 8'd0;
            r_rx[1]      <= 8'd0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_is_read    <= n_is_read;
            r_bit_count  <= n_bit_count;
            r_byte_index <= n_byte_index;
            r_shift      <= n_shift;
            r_hold       <= n_hold;
            r_latched[0] <= n_latched[0];
            r_latched[1] <= n_latched[1];
            r_latched[2] <= n_latched[2];
            r_rx[0]      <= n_rx[0];
            r_rx[1]      <= n_rx[1];
            r_scl        <= n_scl;
            r_sda        <= n_sda;
        end
    end

endmodule
